@@ hw/rtl/dmf_pkg.sv @@
// ----------------------------------------------------------------------------
// dmf_pkg
// Shared sizes, row layout and controller/datapath command and status types
// for the duplicate message filter.
// ----------------------------------------------------------------------------
package dmf_pkg;

    localparam int SOURCES       = 16;
    localparam int HISTORY_DEPTH = 5;

    localparam int ID_W     = 32;
    localparam int SERIAL_W = 8;
    localparam int IDX_W    = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int POS_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    // input beat: source_id then serial_num, padded to whole bytes
    localparam int S_DATA_W = ((ID_W + SERIAL_W + 7) / 8) * 8;
    // output beat: duplicate then new_source, padded to one byte
    localparam int M_DATA_W = 8;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SOURCES - 1);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(HISTORY_DEPTH - 1);

    // one table row: address, serial history and history write position
    typedef struct packed {
        logic [ID_W-1:0]                         addr;
        logic [HISTORY_DEPTH-1:0][SERIAL_W-1:0]  hist;
        logic [POS_W-1:0]                        pos;
    } t_row;

    typedef struct packed {
        logic             capture;   // latch the input beat
        logic             rd_en;     // read the row at rd_addr
        logic [IDX_W-1:0] rd_addr;
        logic             rd_repl;   // advance replace pointer, read its row
        logic             take_hit;  // matching row decides, update if new
        logic             take_repl; // overwrite replaced row
        logic             load_out;  // move result into the output register
    } t_cmd;

    typedef struct packed {
        logic match;     // row just read carries the source address
        logic dup;       // row just read already holds the serial
        logic out_free;  // output register can take a result this cycle
    } t_status;

endpackage

@@ hw/rtl/dmf_ctrl.sv @@
// ----------------------------------------------------------------------------
// dmf_ctrl
// Sequencer for the duplicate message filter: accepts a beat, walks the
// table one row per cycle, then runs the replacement or finishes.
// ----------------------------------------------------------------------------
module dmf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_valid,
    output logic             o_s_ready,
    input  dmf_pkg::t_status i_status,
    output dmf_pkg::t_cmd    o_cmd
);
    import dmf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_REPL = 3'd2;
    localparam logic [2:0] S_RWR  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        o_cmd     = '0;
        o_s_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                // no beat is taken while reset is held
                o_s_ready = i_rst_n;
                if (i_s_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = '0;
                    n_idx         = '0;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                // r_idx is the row whose read data is being compared
                if (i_status.match) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = S_FIN;
                end else if (r_idx == LAST_IDX) begin
                    n_state = S_REPL;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_idx + 1'b1;
                    n_idx         = r_idx + 1'b1;
                end
            end
            S_REPL: begin
                o_cmd.rd_repl = 1'b1;
                n_state       = S_RWR;
            end
            S_RWR: begin
                o_cmd.take_repl = 1'b1;
                n_state         = S_FIN;
            end
            S_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_scan_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= LAST_IDX))
        else $error("scan index beyond table");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> (r_state == S_SCAN && r_idx == '0))
        else $error("accepted beat did not start a scan at row zero");

endmodule

@@ hw/rtl/dmf_dpath.sv @@
// ----------------------------------------------------------------------------
// dmf_dpath
// Datapath of the duplicate message filter: row memory with per-row valid
// bits, compare logic, replace pointer and output register.
// ----------------------------------------------------------------------------
module dmf_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dmf_pkg::ID_W-1:0]      i_source_id,
    input  logic [dmf_pkg::SERIAL_W-1:0]  i_serial_num,
    input  logic                          i_m_ready,
    output logic                          o_m_valid,
    output logic                          o_duplicate,
    output logic                          o_new_source,
    input  dmf_pkg::t_cmd                 i_cmd,
    output dmf_pkg::t_status              o_status
);
    import dmf_pkg::*;

    t_row                r_mem [SOURCES];
    logic [SOURCES-1:0]  r_vld;
    t_row                r_rdata;
    logic                r_rvld;
    logic [ID_W-1:0]     r_id;
    logic [SERIAL_W-1:0] r_serial;
    logic [IDX_W-1:0]    r_rp;
    logic [IDX_W-1:0]    r_cmp_idx;
    logic                r_res_dup;
    logic                r_res_new;
    logic                r_m_valid;
    logic                r_dup_q;
    logic                r_new_q;

    t_row             row;
    t_row             hit_row;
    t_row             repl_row;
    logic [POS_W-1:0] pos_next;
    logic [IDX_W-1:0] rp_next;
    logic             any_dup;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    t_row             wr_row;
    logic [IDX_W-1:0] rd_addr;

    // rows never written read as the reset value
    assign row = r_rvld ? r_rdata : '0;

    always_comb begin
        any_dup = 1'b0;
        for (int s = 0; s < HISTORY_DEPTH; s++) begin
            if (row.hist[s] == r_serial) begin
                any_dup = 1'b1;
            end
        end
    end

    assign pos_next = (row.pos == LAST_POS) ? '0 : row.pos + 1'b1;
    assign rp_next  = (r_rp == LAST_IDX) ? '0 : r_rp + 1'b1;

    always_comb begin
        hit_row      = row;
        hit_row.pos  = pos_next;
        for (int s = 0; s < HISTORY_DEPTH; s++) begin
            if (POS_W'(s) == pos_next) begin
                hit_row.hist[s] = r_serial;
            end
        end
        // replacement keeps the former owner's other slots and position
        repl_row         = row;
        repl_row.addr    = r_id;
        repl_row.hist[0] = r_serial;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cmp_idx;
        wr_row  = hit_row;
        priority if (i_cmd.take_repl) begin
            wr_en   = 1'b1;
            wr_addr = r_rp;
            wr_row  = repl_row;
        end else if (i_cmd.take_hit && !any_dup) begin
            wr_en = 1'b1;
        end
    end

    assign rd_addr = i_cmd.rd_repl ? rp_next : i_cmd.rd_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en || i_cmd.rd_repl) begin
            r_rdata   <= r_mem[rd_addr];
            r_cmp_idx <= rd_addr;
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_id     <= i_source_id;
            r_serial <= i_serial_num;
        end
        if (i_cmd.take_hit) begin
            r_res_dup <= any_dup;
            r_res_new <= 1'b0;
        end else if (i_cmd.take_repl) begin
            r_res_dup <= 1'b0;
            r_res_new <= 1'b1;
        end
        if (i_cmd.load_out) begin
            r_dup_q <= r_res_dup;
            r_new_q <= r_res_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rvld    <= 1'b0;
            r_rp      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en || i_cmd.rd_repl) begin
                r_rvld <= r_vld[rd_addr];
            end
            if (i_cmd.rd_repl) begin
                r_rp <= rp_next;
            end
            if (i_cmd.load_out) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_status.match    = (row.addr == r_id);
    assign o_status.dup      = any_dup;
    assign o_status.out_free = !r_m_valid || i_m_ready;

    assign o_m_valid    = r_m_valid;
    assign o_duplicate  = r_dup_q;
    assign o_new_source = r_new_q;

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_m_valid || i_m_ready))
        else $error("result loaded over an unaccepted beat");

    a_result_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_valid |-> !(r_dup_q && r_new_q))
        else $error("result flagged both duplicate and new source");

    a_repl_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_repl |=> r_vld[$past(r_rp)])
        else $error("replaced row not marked valid");

endmodule

@@ hw/rtl/duplicate_message_filter.sv @@
// ----------------------------------------------------------------------------
// duplicate_message_filter
// Flags received messages whose serial number was already seen for their
// source address; unknown sources take over a table row in round robin.
// ----------------------------------------------------------------------------
//  channel  direction  beat contents (lowest bit first)
//  s_axis   in         tdata: source_id[31:0], serial_num[39:32]
//  m_axis   out        tdata: duplicate[0], new_source[1], zero[7:2]
//
//  one beat at a time: accept, compare the table rows in order from row 0,
//  then a result. a hit in row k ends the walk there, a miss walks all
//  SOURCES rows (16) and then replaces the row at the replace pointer; the
//  walk reads the single-port row memory once per cycle.
//  reset clears the row valid bits, so every row reads as all zeros at once.
//  s_axis_tready is low while a beat is in work; a stalled m_axis holds the
//  next result back, and no further beat is taken until it is loaded.
// ----------------------------------------------------------------------------
module duplicate_message_filter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [dmf_pkg::S_DATA_W-1:0]   s_axis_tdata,  // source_id, serial_num
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [dmf_pkg::M_DATA_W-1:0]   m_axis_tdata   // duplicate, new_source
);
    import dmf_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    duplicate;
    logic    new_source;

    dmf_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    dmf_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_source_id  (s_axis_tdata[ID_W-1:0]),
        .i_serial_num (s_axis_tdata[ID_W +: SERIAL_W]),
        .i_m_ready    (m_axis_tready),
        .o_m_valid    (m_axis_tvalid),
        .o_duplicate  (duplicate),
        .o_new_source (new_source),
        .i_cmd        (cmd),
        .o_status     (status)
    );

    assign m_axis_tdata = {{(M_DATA_W - 2){1'b0}}, new_source, duplicate};

endmodule

@@ sim/dmf_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dmf_checker
// Watches both stream channels of the duplicate message filter. It keeps its
// own copy of the source table and serial history, predicts the verdict of
// every accepted message beat, and compares each result beat with the oldest
// prediction.
// ----------------------------------------------------------------------------
module dmf_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [dmf_pkg::S_DATA_W-1:0]  i_s_tdata,   // source_id, serial_num
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [dmf_pkg::M_DATA_W-1:0]  i_m_tdata,   // duplicate, new_source
    output int                            o_fail_count,
    output int                            o_pending
);
    import dmf_pkg::*;

    typedef struct packed {
        logic duplicate;
        logic new_source;
    } t_verdict;

    logic [ID_W-1:0]     addr_tbl [SOURCES];
    logic [SERIAL_W-1:0] hist_tbl [SOURCES][HISTORY_DEPTH];
    logic [POS_W-1:0]    wr_pos   [SOURCES];
    logic [IDX_W-1:0]    repl_ptr;

    t_verdict verdicts_due [$];
    int       mismatches = 0;

    // updates the table copy and returns the verdict of one message
    function automatic t_verdict classify_msg(input logic [ID_W-1:0] id,
                                              input logic [SERIAL_W-1:0] sn);
        t_verdict         v;
        int               hit;
        logic [POS_W-1:0] p;
        v   = '0;
        hit = -1;
        // lowest matching row wins, later rows with the same address are shadowed
        for (int e = 0; e < SOURCES; e++) begin
            if (hit < 0 && addr_tbl[e] == id) hit = e;
        end
        if (hit >= 0) begin
            for (int s = 0; s < HISTORY_DEPTH; s++) begin
                if (hist_tbl[hit][s] == sn) v.duplicate = 1'b1;
            end
            if (!v.duplicate) begin
                p = (wr_pos[hit] == LAST_POS) ? '0 : wr_pos[hit] + 1'b1;
                wr_pos[hit]      = p;
                hist_tbl[hit][p] = sn;
            end
        end else begin
            // pointer moves first; old slots and position stay with the row
            repl_ptr = (repl_ptr == LAST_IDX) ? '0 : repl_ptr + 1'b1;
            addr_tbl[repl_ptr]    = id;
            hist_tbl[repl_ptr][0] = sn;
            v.new_source          = 1'b1;
        end
        return v;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            for (int e = 0; e < SOURCES; e++) begin
                addr_tbl[e] = '0;
                wr_pos[e]   = '0;
                for (int s = 0; s < HISTORY_DEPTH; s++) hist_tbl[e][s] = '0;
            end
            repl_ptr = '0;
            verdicts_due.delete();
        end else begin
            // result first: it always belongs to an earlier message beat
            if (i_m_tvalid && i_m_tready) begin
                got.duplicate  = i_m_tdata[0];
                got.new_source = i_m_tdata[1];
                if (verdicts_due.size() == 0) begin
                    $error("result beat with nothing outstanding: dup %0b, new %0b",
                           got.duplicate, got.new_source);
                    mismatches++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.duplicate !== want.duplicate) begin
                        $error("duplicate: expected %0b, actual %0b",
                               want.duplicate, got.duplicate);
                        mismatches++;
                    end
                    if (got.new_source !== want.new_source) begin
                        $error("new_source: expected %0b, actual %0b",
                               want.new_source, got.new_source);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                verdicts_due.push_back(classify_msg(i_s_tdata[ID_W-1:0],
                                                    i_s_tdata[ID_W +: SERIAL_W]));
        end
        o_pending    <= verdicts_due.size();
        o_fail_count <= mismatches;
    end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the duplicate message filter: a directed run through reset
// contents, history wrap and row replacement, then random message streams
// from a small pool of senders under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
    import dmf_pkg::*;

    localparam int RANDOM_MSGS  = 1224;
    localparam int POOL_SIZE    = 24;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 400000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_DATA_W-1:0]  s_axis_tdata;   // source_id, serial_num
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_DATA_W-1:0]  m_axis_tdata;   // duplicate, new_source

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    int cycles    = 0;

    duplicate_message_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    dmf_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : rx_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // valid stays up between back-to-back beats, it only drops while idling
    task automatic send_msg(input logic [ID_W-1:0] id, input logic [SERIAL_W-1:0] sn);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_DATA_W'({sn, id});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin : stim
        logic [ID_W-1:0]     id_pool [POOL_SIZE];
        logic [SERIAL_W-1:0] sn_base [POOL_SIZE];
        int                  phase_idle  [4];
        int                  phase_stall [4];
        logic [ID_W-1:0]     id;
        logic [SERIAL_W-1:0] sn;
        int                  k;
        int                  r;

        phase_idle  = '{0, 77, 0, 36};
        phase_stall = '{0, 0, 77, 36};

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_pct  = 20;
        stall_pct = 20;
        // every row reads as address 0 with zero history after reset
        send_msg(32'h0000_0000, 8'h00);
        send_msg(32'h0000_0000, 8'hFF);
        send_msg(32'h0000_0000, 8'hFF);
        send_msg(32'hFFFF_FFFF, 8'hFF);
        // stale zeros in the replaced row still count as seen
        send_msg(32'hFFFF_FFFF, 8'h00);
        // walk the history around, the last one lands back in slot 0
        for (int s = 1; s <= HISTORY_DEPTH; s++) send_msg(32'hFFFF_FFFF, 8'(s));
        // fill the remaining rows; row 0 is taken last
        for (int e = 2; e < SOURCES; e++)
            send_msg(32'hA5A5_0000 + e * 32'h0101_0101, 8'(8'h80 + e));
        send_msg(32'h5A5A_C3C3, 8'h40);
        // row 0 keeps the former owner's serial in slot 1
        send_msg(32'h5A5A_C3C3, 8'hFF);
        drain_results();

        id_pool[0] = '0;
        id_pool[1] = '1;
        for (int p = 2; p < POOL_SIZE; p++) id_pool[p] = $urandom;
        for (int p = 0; p < POOL_SIZE; p++) sn_base[p] = 8'($urandom);

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = phase_idle[ph];
            stall_pct = phase_stall[ph];
            // receiver holds off while the sender keeps offering
            if (ph == 0) hold_req = 1'b1;
            repeat (RANDOM_MSGS / 4) begin
                k = $urandom_range(POOL_SIZE - 1);
                r = $urandom_range(99);
                if (r < 70) begin
                    // near-recent serials from a known sender: many repeats
                    id = id_pool[k];
                    sn = sn_base[k] + 8'($urandom_range(7));
                    if ($urandom_range(9) == 0) sn_base[k] = sn_base[k] + 8'($urandom_range(1, 6));
                end else if (r < 85) begin
                    id = id_pool[k];
                    sn = 8'($urandom);
                end else begin
                    id = $urandom;
                    sn = 8'($urandom);
                end
                send_msg(id, sn);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
